FILE: rtl/alcd_pkg.sv
// Shared types, command codes and constants of the ASCII line command decoder.
package alcd_pkg;

   localparam int LINE_BYTES_DEFAULT = 64;

   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_L    = 8'h4C;
   localparam logic [7:0] CHAR_P    = 8'h50;
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_T    = 8'h54;
   localparam logic [7:0] CHAR_W    = 8'h57;

   typedef enum logic [0:0] {
      OP_RX_BYTE = 1'b0,
      OP_TAKE    = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      CMD_IDLE       = 4'd0,
      CMD_PUMP_START = 4'd1,
      CMD_PUMP_STOP  = 4'd2,
      CMD_LAMP_ON    = 4'd3,
      CMD_LAMP_OFF   = 4'd4,
      CMD_AUTO       = 4'd5,
      CMD_WATER      = 4'd6,
      CMD_SOIL_THR   = 4'd7,
      CMD_LIGHT_THR  = 4'd8
   } cmd_code_type;

   typedef struct packed {
      op_type      opcode;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      cmd_code_type command_code;
      logic [7:0]   command_value;
      logic         value_valid;
   } rsp_type;

   // Multiplies the running value by ten and adds one decimal digit, modulo 256.
   function automatic logic [7:0] digit_step(input logic [7:0] acc, input logic [7:0] chr);
      logic [7:0] digit;
      digit = chr - CHAR_ZERO;
      return {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + digit;
   endfunction

endpackage

FILE: rtl/ascii_line_command_decoder_unit.sv
// Top level of the ASCII line command decoder: handshakes, result register and skid stage.
//
// Items arrive on the req_ channel. A received-byte item updates the line
// held inside the block and gives no result. A take item gives exactly one
// result on the rsp_ channel: the command decoded from the finished line, or
// the none code when no line is ready; only a finished line is then emptied.
// Each channel moves one transfer when its valid and ready are both high.
//
// A take item's result is registered: it enters the output register, or the
// skid stage while the output register is held, and one item can be accepted in
// every cycle while req_ready is high; the line state is registered per item.
// Results wait in an output register backed by a one-entry skid stage, so
// req_ready stays high while one result is stalled and drops only when both
// are full; it depends on registers alone.
// Synchronous reset empties the line, clears the first three bytes and the
// running value, and discards any result not yet transferred.
module ascii_line_command_decoder_unit
   import alcd_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    req_fire;
   logic    rsp_fire;
   logic    push;
   rsp_type decoded;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;

   assign req_ready   = !skid_valid_ff;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign rsp_fire    = out_valid_ff && rsp_ready;
   assign push        = req_fire && (req_payload.opcode == OP_TAKE);

   alcd_line_unit #(
      .LINE_BYTES (LINE_BYTES)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .item_fire (req_fire),
      .item      (req_payload),
      .decoded   (decoded)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || rsp_fire) begin
            out_in       = decoded;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = decoded;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef ASSERT_OFF
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a result while the output register is empty");

   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.opcode == OP_TAKE) |=> rsp_valid)
      else $error("accepted take item produced no result");

   a_byte_gives_none: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.opcode == OP_RX_BYTE && !rsp_valid) |=> !rsp_valid)
      else $error("received byte item produced a result");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_fire) |=> (rsp_valid && !skid_valid_ff))
      else $error("skid stage did not move into the output register");
`endif

endmodule

FILE: rtl/alcd_line_unit.sv
// Line assembly state and command decode of the ASCII line command decoder.
module alcd_line_unit
   import alcd_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    item_fire,
   input  req_type item,
   output rsp_type decoded
);

   localparam int LEN_W = $clog2(LINE_BYTES);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BYTES - 1);

   logic [7:0]       head_ff [3];
   logic [7:0]       head_in [3];
   logic [LEN_W-1:0] length_ff, length_in;
   logic             ready_ff, ready_in;
   logic [7:0]       digit_ff, digit_in;

   logic is_end;
   logic is_digit;

   assign is_end   = (item.rx_byte == CHAR_LF) || (item.rx_byte == CHAR_CR);
   assign is_digit = (item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE);

   always_comb begin
      head_in   = head_ff;
      length_in = length_ff;
      ready_in  = ready_ff;
      digit_in  = digit_ff;
      if (item_fire) begin
         if (item.opcode == OP_TAKE) begin
            if (ready_ff) begin
               ready_in  = 1'b0;
               length_in = '0;
            end
         end else if (is_end) begin
            if (length_ff != '0) begin
               for (int i = 0; i < 3; i++) begin
                  if (length_ff == LEN_W'(i)) begin
                     head_in[i] = 8'h00;
                  end
               end
               ready_in = 1'b1;
            end
         end else if (length_ff < LEN_MAX) begin
            for (int i = 0; i < 3; i++) begin
               if (length_ff == LEN_W'(i)) begin
                  head_in[i] = item.rx_byte;
               end
            end
            if (length_ff == '0) begin
               digit_in = 8'h00;
            end else if (is_digit) begin
               digit_in = digit_step(digit_ff, item.rx_byte);
            end
            length_in = length_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '{default: 8'h00};
         length_ff <= '0;
         ready_ff  <= 1'b0;
         digit_ff  <= 8'h00;
      end else begin
         head_ff   <= head_in;
         length_ff <= length_in;
         ready_ff  <= ready_in;
         digit_ff  <= digit_in;
      end
   end

   always_comb begin
      decoded.command_code  = CMD_IDLE;
      decoded.command_value = 8'h00;
      decoded.value_valid   = 1'b0;
      if (ready_ff) begin
         if (head_ff[0] == CHAR_P && head_ff[1] == CHAR_ONE) begin
            decoded.command_code = CMD_PUMP_START;
         end else if (head_ff[0] == CHAR_P && head_ff[1] == CHAR_ZERO) begin
            decoded.command_code = CMD_PUMP_STOP;
         end else if (head_ff[0] == CHAR_L && head_ff[1] == CHAR_ONE) begin
            decoded.command_code = CMD_LAMP_ON;
         end else if (head_ff[0] == CHAR_L && head_ff[1] == CHAR_ZERO) begin
            decoded.command_code = CMD_LAMP_OFF;
         end else if (head_ff[0] == CHAR_A && head_ff[1] == CHAR_ONE) begin
            decoded.command_code = CMD_AUTO;
         end else if (head_ff[0] == CHAR_W) begin
            decoded.command_code = CMD_WATER;
            if (length_ff > LEN_W'(1)) begin
               decoded.command_value = digit_ff;
               decoded.value_valid   = 1'b1;
            end
         end else if (head_ff[0] == CHAR_S && head_ff[1] == CHAR_T) begin
            decoded.command_code  = CMD_SOIL_THR;
            decoded.command_value = head_ff[2];
            decoded.value_valid   = 1'b1;
         end else if (head_ff[0] == CHAR_L && head_ff[1] == CHAR_T) begin
            decoded.command_code  = CMD_LIGHT_THR;
            decoded.command_value = head_ff[2];
            decoded.value_valid   = 1'b1;
         end
      end
   end

endmodule
